/* hw/rtl/mcds_pkg.sv */
`default_nettype none
package mcds_pkg;

    localparam int BEATS_MAX        = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_LOG2        = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_QTR         = SINE_TABLE_DEPTH / 4;
    localparam int SINE_SH          = 32 - SINE_LOG2;
    localparam int SINE_JW          = SINE_LOG2 - 1;

    localparam int APB_AW  = 5;
    localparam int DIV_NW  = 40;
    localparam int DIV_DW  = 22;
    localparam int DIV_CW  = $clog2(DIV_NW);

    localparam logic [2:0] REG_RATE   = 3'd0;
    localparam logic [2:0] REG_BPM    = 3'd1;
    localparam logic [2:0] REG_BPB    = 3'd2;
    localparam logic [2:0] REG_DRONE  = 3'd3;
    localparam logic [2:0] REG_CLICK  = 3'd4;
    localparam logic [2:0] REG_ACCENT = 3'd5;

    localparam logic [14:0] CLICK_GAIN = 15'd20000;
    localparam logic [14:0] DRONE_GAIN = 15'd12000;

    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598668;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026995;
    localparam logic [63:0] C9 = 64'd172272;

    typedef struct packed {
        logic [16:0] sample_rate;
        logic [8:0]  tempo_bpm;
        logic [4:0]  beats_per_bar;
        logic [31:0] drone_step;
        logic [31:0] click_step;
        logic [31:0] accent_step;
        logic [10:0] click_samples;
        logic [9:0]  ramp_len;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic prep;
        logic iv_start;
        logic iv_add;
        logic rom;
        logic mul1;
        logic mul2;
        logic od_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic onset;
        logic active;
        logic div_done;
        logic out_free;
    } t_sts;

    typedef logic [14:0] t_sine_rom [0:SINE_QTR];

    // quarter wave magnitude, odd polynomial in q30
    function automatic t_sine_rom sine_rom_build();
        t_sine_rom tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] m;
        for (int j = 0; j <= SINE_QTR; j++) begin
            x  = 64'(j) << SINE_SH;
            x2 = (x * x) >> 30;
            t  = C9;
            t  = C7 - ((x2 * t) >> 30);
            t  = C5 - ((x2 * t) >> 30);
            t  = C3 - ((x2 * t) >> 30);
            t  = C1 - ((x2 * t) >> 30);
            s  = (x * t) >> 30;
            m  = (s * 64'd32767 + 64'd536870912) >> 30;
            if (m > 64'd32767) m = 64'd32767;
            tab[j] = m[14:0];
        end
        return tab;
    endfunction

    localparam t_sine_rom SINE_ROM = sine_rom_build();

endpackage
`default_nettype wire

/* hw/rtl/mcds_cfg.sv */
`default_nettype none
module mcds_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mcds_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output mcds_pkg::t_cfg                     o_cfg
);
    import mcds_pkg::*;

    t_cfg        r_cfg;
    logic        w_wr;
    logic [2:0]  w_idx;
    logic [16:0] w_rate;
    logic [8:0]  w_bpm;
    logic [4:0]  w_bpb;
    logic [34:0] w_recip;

    assign w_wr  = psel & penable & pwrite;
    assign w_idx = paddr[APB_AW-1:2];

    always_comb begin
        w_rate = pwdata[16:0];
        if (w_rate < 17'd8000) w_rate = 17'd8000;
        else if (w_rate > 17'd96000) w_rate = 17'd96000;
        w_bpm = pwdata[8:0];
        if (w_bpm < 9'd20) w_bpm = 9'd20;
        else if (w_bpm > 9'd300) w_bpm = 9'd300;
        w_bpb = pwdata[4:0];
        if (w_bpb < 5'd1) w_bpb = 5'd1;
        else if (w_bpb > 5'(BEATS_MAX)) w_bpb = 5'(BEATS_MAX);
    end

    // rate/50 and rate/100 by one reciprocal product, exact over the clamped range
    assign w_recip = 35'(w_rate) * 35'd167773;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_rate   <= 17'd48000;
            r_cfg.tempo_bpm     <= 9'd120;
            r_cfg.beats_per_bar <= 5'd4;
            r_cfg.drone_step    <= 32'd39370534;
            r_cfg.click_step    <= 32'd89478485;
            r_cfg.accent_step   <= 32'd134217728;
            r_cfg.click_samples <= 11'd960;
            r_cfg.ramp_len      <= 10'd480;
        end else if (w_wr) begin
            case (w_idx)
                REG_RATE: begin
                    r_cfg.sample_rate   <= w_rate;
                    r_cfg.click_samples <= w_recip[33:23];
                    r_cfg.ramp_len      <= w_recip[33:24];
                end
                REG_BPM:    r_cfg.tempo_bpm     <= w_bpm;
                REG_BPB:    r_cfg.beats_per_bar <= w_bpb;
                REG_DRONE:  r_cfg.drone_step    <= pwdata;
                REG_CLICK:  r_cfg.click_step    <= pwdata;
                REG_ACCENT: r_cfg.accent_step   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_RATE:   prdata = 32'(r_cfg.sample_rate);
            REG_BPM:    prdata = 32'(r_cfg.tempo_bpm);
            REG_BPB:    prdata = 32'(r_cfg.beats_per_bar);
            REG_DRONE:  prdata = r_cfg.drone_step;
            REG_CLICK:  prdata = r_cfg.click_step;
            REG_ACCENT: prdata = r_cfg.accent_step;
            default:    prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule
`default_nettype wire

/* hw/rtl/mcds_div.sv */
`default_nettype none
module mcds_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mcds_pkg::DIV_NW-1:0]   i_num,
    input  wire logic [mcds_pkg::DIV_DW-1:0]   i_den,
    output logic [mcds_pkg::DIV_NW-1:0]        o_quo,
    output logic                               o_done
);
    import mcds_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   w_sh;
    logic [DIV_DW:0]   w_sub;

    // restoring division, one quotient bit per cycle
    assign w_sh  = {r_rem, r_q[DIV_NW-1]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= DIV_CW'(DIV_NW - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (w_sh >= {1'b0, r_den}) begin
                r_rem <= w_sub[DIV_DW-1:0];
                r_q   <= {r_q[DIV_NW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DIV_DW-1:0];
                r_q   <= {r_q[DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;

endmodule
`default_nettype wire

/* hw/rtl/mcds_dp.sv */
`default_nettype none
module mcds_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mcds_pkg::t_cmd  i_cmd,
    output mcds_pkg::t_sts       o_sts,
    input  wire mcds_pkg::t_cfg  i_cfg,
    input  wire logic            i_mode,
    input  wire logic            i_drone_on,
    input  wire logic            i_end_of_block,
    input  wire logic            i_out_stall,
    output logic                 o_out_valid,
    output logic signed [15:0]   o_audio_sample,
    output logic                 o_beat_onset,
    output logic [3:0]           o_beat_index,
    output logic [31:0]          o_beats_total,
    output logic                 o_block_end
);
    import mcds_pkg::*;

    function automatic logic [4:0] mod_small(input logic [4:0] v, input logic [4:0] m);
        logic [5:0] rem;
        rem = '0;
        for (int i = 4; i >= 0; i--) begin
            rem = {rem[4:0], v[i]};
            if (rem >= {1'b0, m}) rem = rem - {1'b0, m};
        end
        return rem[4:0];
    endfunction

    // per item inputs
    logic r_mode, r_gate, r_eob;

    // generator state
    logic [31:0] r_osc_phase;
    logic [63:0] r_grid;
    logic [63:0] r_next;
    logic [4:0]  r_bc;
    logic [31:0] r_beats;
    logic [10:0] r_click_rem;
    logic        r_accent;
    logic [9:0]  r_drone_lvl;
    logic        r_onset;
    logic        r_active;

    // arithmetic pipeline
    logic [SINE_JW-1:0] r_rom_j;
    logic               r_neg;
    logic [14:0]        r_emag;
    logic [29:0]        r_a;
    logic [21:0]        r_b;
    logic [21:0]        r_den;
    logic [32:0]        r_ivprod;
    logic [51:0]        r_mag;

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_o_sample;
    logic               r_o_onset;
    logic [3:0]         r_o_index;
    logic [31:0]        r_o_total;
    logic               r_o_end;

    logic                 w_onset;
    logic [4:0]           w_bc_new;
    logic                 w_accent_new;
    logic [10:0]          w_cr_new;
    logic [31:0]          w_base;
    logic [9:0]           w_lvl_new;
    logic                 w_active;
    logic [31:0]          w_src;
    logic [SINE_LOG2-1:0] w_idx;
    logic [SINE_JW-1:0]   w_k;
    logic [SINE_JW-1:0]   w_j;
    logic [31:0]          w_step;
    logic [53:0]          w_osum;
    logic                 w_div_start;
    logic [DIV_NW-1:0]    w_div_num;
    logic [DIV_DW-1:0]    w_div_den;
    logic [DIV_NW-1:0]    w_quo;
    logic                 w_div_done;
    logic signed [15:0]   w_sample;

    assign w_onset = !r_mode && (r_grid >= r_next);

    always_comb begin
        if (!w_onset) w_bc_new = r_bc;
        else if (r_bc == 5'd31) w_bc_new = 5'd0;
        else w_bc_new = mod_small(r_bc + 5'd1, i_cfg.beats_per_bar);
        w_accent_new = w_onset ? (w_bc_new == 5'd0 && i_cfg.beats_per_bar > 5'd1) : r_accent;
        w_cr_new     = w_onset ? i_cfg.click_samples : r_click_rem;
        w_base       = w_onset ? 32'd0 : r_osc_phase;
        w_active     = r_mode | (w_cr_new != 11'd0);
        if (r_gate) begin
            w_lvl_new = (r_drone_lvl >= i_cfg.ramp_len) ? i_cfg.ramp_len : r_drone_lvl + 10'd1;
        end else begin
            w_lvl_new = (r_drone_lvl == 10'd0) ? 10'd0 : r_drone_lvl - 10'd1;
            if (w_lvl_new > i_cfg.ramp_len) w_lvl_new = i_cfg.ramp_len;
        end
        if (r_mode) w_step = i_cfg.drone_step;
        else w_step = w_accent_new ? i_cfg.accent_step : i_cfg.click_step;
    end

    // quarter wave addressing: mirror odd quadrants, negate the second half cycle
    assign w_src = r_mode ? r_osc_phase : w_base;
    assign w_idx = w_src[31 -: SINE_LOG2];
    assign w_k   = SINE_JW'(w_idx[SINE_LOG2-3:0]);
    assign w_j   = w_idx[SINE_LOG2-2] ? SINE_JW'(SINE_QTR) - w_k : w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc_phase <= '0;
            r_grid      <= '0;
            r_next      <= '0;
            r_bc        <= 5'd31;
            r_beats     <= '0;
            r_click_rem <= '0;
            r_accent    <= 1'b0;
            r_drone_lvl <= '0;
            r_onset     <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            if (i_cmd.prep) begin
                r_onset  <= w_onset;
                r_active <= w_active;
                if (!r_mode) begin
                    r_bc     <= w_bc_new;
                    r_beats  <= r_beats + 32'(w_onset);
                    r_accent <= w_accent_new;
                    r_grid   <= r_grid + 64'd1000;
                    if (w_active) begin
                        r_click_rem <= w_cr_new - 11'd1;
                        r_osc_phase <= w_base + w_step;
                    end else begin
                        r_click_rem <= w_cr_new;
                        r_osc_phase <= w_base;
                    end
                end else begin
                    r_drone_lvl <= w_lvl_new;
                    r_osc_phase <= r_osc_phase + w_step;
                end
            end
            if (i_cmd.iv_add) r_next <= r_next + 64'(w_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_gate <= i_drone_on;
            r_eob  <= i_end_of_block;
        end
        if (i_cmd.prep) begin
            r_rom_j  <= w_j;
            r_neg    <= w_idx[SINE_LOG2-1];
            r_ivprod <= 33'(i_cfg.sample_rate) * 33'd60000;
            if (!r_mode) begin
                r_b   <= 22'(w_cr_new) * 22'(w_cr_new);
                r_den <= 22'(i_cfg.click_samples) * 22'(i_cfg.click_samples);
            end else begin
                r_b   <= 22'(w_lvl_new);
                r_den <= 22'(i_cfg.ramp_len);
            end
        end
        if (i_cmd.rom)  r_emag <= SINE_ROM[r_rom_j];
        if (i_cmd.mul1) r_a    <= 30'(r_emag) * 30'(r_mode ? DRONE_GAIN : CLICK_GAIN);
        if (i_cmd.mul2) r_mag  <= 52'(r_a) * 52'(r_b);
    end

    // round half away: floor((2*mag + d) / (2*d)), d = den * 2^15
    assign w_osum      = 54'({r_mag, 1'b0}) + 54'({r_den, 15'd0});
    assign w_div_start = i_cmd.iv_start | i_cmd.od_start;
    assign w_div_num   = i_cmd.iv_start ? DIV_NW'(r_ivprod) : DIV_NW'(w_osum[53:16]);
    assign w_div_den   = i_cmd.iv_start ? DIV_DW'(i_cfg.tempo_bpm) : r_den;

    mcds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    always_comb begin
        if (!r_active) w_sample = 16'sd0;
        else if (r_neg) w_sample = (w_quo > DIV_NW'(32768)) ? 16'sh8000 : 16'(16'd0 - w_quo[15:0]);
        else w_sample = (w_quo > DIV_NW'(32767)) ? 16'sd32767 : 16'(w_quo[15:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_sample <= w_sample;
            r_o_onset  <= r_onset;
            r_o_index  <= r_bc[3:0];
            r_o_total  <= r_beats;
            r_o_end    <= r_eob;
        end
    end

    assign o_sts.onset    = r_onset;
    assign o_sts.active   = r_active;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_audio_sample = r_o_sample;
    assign o_beat_onset   = r_o_onset;
    assign o_beat_index   = r_o_index;
    assign o_beats_total  = r_o_total;
    assign o_block_end    = r_o_end;

endmodule
`default_nettype wire

/* hw/rtl/mcds_ctrl.sv */
`default_nettype none
module mcds_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire mcds_pkg::t_sts  i_sts,
    output mcds_pkg::t_cmd       o_cmd
);
    import mcds_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_BRANCH = 4'd2;
    localparam logic [3:0] S_IVDIV  = 4'd3;
    localparam logic [3:0] S_IVWAIT = 4'd4;
    localparam logic [3:0] S_ROM    = 4'd5;
    localparam logic [3:0] S_MUL1   = 4'd6;
    localparam logic [3:0] S_MUL2   = 4'd7;
    localparam logic [3:0] S_ODIV   = 4'd8;
    localparam logic [3:0] S_OWAIT  = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_BRANCH;
            end
            S_BRANCH: begin
                if (i_sts.onset) n_state = S_IVDIV;
                else if (i_sts.active) n_state = S_ROM;
                else n_state = S_OUT;
            end
            S_IVDIV: begin
                o_cmd.iv_start = 1'b1;
                n_state        = S_IVWAIT;
            end
            S_IVWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.iv_add = 1'b1;
                    n_state      = i_sts.active ? S_ROM : S_OUT;
                end
            end
            S_ROM: begin
                o_cmd.rom = 1'b1;
                n_state   = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_ODIV;
            end
            S_ODIV: begin
                o_cmd.od_start = 1'b1;
                n_state        = S_OWAIT;
            end
            S_OWAIT: begin
                if (i_sts.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

/* hw/rtl/metronome_click_and_drone_synth_core.sv */
// metronome click and drone tone generator, one audio sample per transfer
// input channel: i_in_valid / o_in_stall carry one sample tick with mode,
//   drone gate and an end-of-buffer flag; output channel: o_out_valid /
//   i_out_stall carry the sample, onset flag, beat index, beat count and
//   the end-of-buffer copy
// configuration: apb-style, register i at byte address 4*i; rate, tempo and beats
//   per bar writes are clamped, pready is always high; write only while the block is idle
// timing: one item at a time; a silent metronome tick passes the prep, branch
//   and out states only, a sounding sample adds rom, mul1, mul2 and a division
//   on the shared restoring divider, and a beat onset adds the grid interval
//   division on the same divider
// o_in_stall is high from acceptance until the result is loaded into the
//   output register; that register lets the next tick be taken while the
//   previous result still waits on a stalled receiver, and the block only
//   stalls at the final load if the old result has not left yet
// reset: synchronous active low; registers return to their default values,
//   beat counter to all ones (no beat yet), grid, phase and levels to zero
`default_nettype none
module metronome_click_and_drone_synth_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // sample tick channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_mode,
    input  wire logic                          i_drone_on,
    input  wire logic                          i_end_of_block,
    // sample out channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [15:0]                 o_audio_sample,
    output logic                               o_beat_onset,
    output logic [3:0]                         o_beat_index,
    output logic [31:0]                        o_beats_total,
    output logic                               o_block_end,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mcds_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import mcds_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // register file plus derived click and ramp lengths
    mcds_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: steps each sample through the shared datapath units
    mcds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // oscillator, beat grid, envelope, scaling and output register
    mcds_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg          (w_cfg),
        .i_mode         (i_mode),
        .i_drone_on     (i_drone_on),
        .i_end_of_block (i_end_of_block),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_audio_sample (o_audio_sample),
        .o_beat_onset   (o_beat_onset),
        .o_beat_index   (o_beat_index),
        .o_beats_total  (o_beats_total),
        .o_block_end    (o_block_end)
    );

endmodule
`default_nettype wire
